// ===== sv/dedup_fifo_queue_unit_macros.svh =====
// Assertion helpers for the dedup FIFO queue.
`ifndef DEDUP_FIFO_QUEUE_UNIT_MACROS_SVH
`define DEDUP_FIFO_QUEUE_UNIT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define DFQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define DFQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/dfq_pkg.sv =====
`timescale 1ns / 1ps

package dfq_pkg;

  localparam int DATA_W   = 32;
  localparam int OCC_W    = 8;
  localparam int STATUS_W = 3;
  localparam int CMD_W    = 1;
  localparam int OUT_W    = DATA_W + OCC_W;

  // Command codes carried on the input tuser
  localparam logic [CMD_W-1:0] CMD_ENQ = 1'b0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 1'b1;

  // Result status codes carried on the output tuser
  typedef enum logic [STATUS_W-1:0] {
    STS_ENQUEUED  = 3'd0,
    STS_DUPLICATE = 3'd1,
    STS_FULL      = 3'd2,
    STS_DEQUEUED  = 3'd3,
    STS_EMPTY     = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DEQ  = 3'b100
  } state_t;

endpackage

// ===== sv/dedup_fifo_queue_unit.sv =====
// Dequeue: the head is read from memory on the input transfer; the result is loaded once the output is free.
// Enqueue: the duplicate search reads one stored entry per cycle through the single memory
// read port and stops early on a match; the result is loaded once the output is free.
// One command is in work at a time; the next is taken the cycle after its result is loaded.
// Synchronous active-high reset empties the queue and drops any pending result; stored words
// are not cleared.
`timescale 1ns / 1ps
`include "dedup_fifo_queue_unit_macros.svh"

module dedup_fifo_queue_unit #(
  parameter int DEPTH = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [dfq_pkg::DATA_W-1:0]     s_axis_tdata,   // [31:0] item_value
  input  logic [dfq_pkg::CMD_W-1:0]      s_axis_tuser,   // [0] cmd
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [dfq_pkg::OUT_W-1:0]      m_axis_tdata,   // [31:0] removed_value, [39:32] occupancy
  output logic [dfq_pkg::STATUS_W-1:0]   m_axis_tuser    // [2:0] status
);

  import dfq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Entry storage, circular
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     head, head_next;
  logic [AW-1:0]     tail, tail_next;
  logic [AW-1:0]     scan_ptr, scan_ptr_next;
  logic [CW-1:0]     issue_left, issue_left_next;
  logic              cmp_valid, cmp_valid_next;
  logic [DATA_W-1:0] value;

  logic              out_valid;
  status_t           out_status;
  logic [DATA_W-1:0] out_removed;
  logic [OCC_W-1:0]  out_occ;

  logic              s_fire, out_free, hit;
  logic              load, rd_en, wr_en;
  logic [AW-1:0]     rd_addr;
  status_t           ld_status;
  logic [DATA_W-1:0] ld_removed;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign hit           = cmp_valid && (rd_data == value);

  // Sequence the search, append and removal
  always_comb begin
    state_next      = state;
    count_next      = count;
    head_next       = head;
    tail_next       = tail;
    scan_ptr_next   = scan_ptr;
    issue_left_next = issue_left;
    cmp_valid_next  = cmp_valid;
    load            = 1'b0;
    ld_status       = STS_EMPTY;
    ld_removed      = '0;
    rd_en           = 1'b0;
    rd_addr         = scan_ptr;
    wr_en           = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser == CMD_DEQ) begin
            rd_en      = (count != '0);
            rd_addr    = head;
            state_next = ST_DEQ;
          end else begin
            scan_ptr_next   = head;
            issue_left_next = count;
            cmp_valid_next  = 1'b0;
            state_next      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          if (out_free) begin
            load           = 1'b1;
            ld_status      = STS_DUPLICATE;
            cmp_valid_next = 1'b0;
            state_next     = ST_IDLE;
          end
        end else if (issue_left != '0) begin
          rd_en           = 1'b1;
          rd_addr         = scan_ptr;
          scan_ptr_next   = (scan_ptr == AW'(DEPTH - 1)) ? '0 : scan_ptr + 1'b1;
          issue_left_next = issue_left - 1'b1;
          cmp_valid_next  = 1'b1;
        end else if (cmp_valid) begin
          cmp_valid_next = 1'b0;
        end else if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
          if (count == CW'(DEPTH)) begin
            ld_status = STS_FULL;
          end else begin
            ld_status  = STS_ENQUEUED;
            wr_en      = 1'b1;
            tail_next  = (tail == AW'(DEPTH - 1)) ? '0 : tail + 1'b1;
            count_next = count + 1'b1;
          end
        end
      end
      ST_DEQ: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
          if (count == '0) begin
            ld_status = STS_EMPTY;
          end else begin
            ld_status  = STS_DEQUEUED;
            ld_removed = rd_data;
            head_next  = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      head       <= '0;
      tail       <= '0;
      scan_ptr   <= '0;
      issue_left <= '0;
      cmp_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      head       <= head_next;
      tail       <= tail_next;
      scan_ptr   <= scan_ptr_next;
      issue_left <= issue_left_next;
      cmp_valid  <= cmp_valid_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the command value and the result payload
  always_ff @(posedge clk) begin
    if (s_fire) begin
      value <= s_axis_tdata;
    end
    if (load) begin
      out_status  <= ld_status;
      out_removed <= ld_removed;
      out_occ     <= OCC_W'(count_next);
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_occ, out_removed};
  assign m_axis_tuser  = out_status;

  // Design checks
  `DFQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH), "entry count above depth")
  `DFQ_ASSERT_NOW(a_ptr_meet, clk, rst, (count == '0) || (count == CW'(DEPTH)), head == tail, "head and tail disagree with count")
  `DFQ_ASSERT_NEXT(a_deq_path, clk, rst, s_fire && (s_axis_tuser == CMD_DEQ), state == ST_DEQ, "dequeue did not enter removal step")
  `DFQ_ASSERT_NOW(a_hit_in_scan, clk, rst, cmp_valid, state == ST_SCAN, "compare pending outside search")

endmodule

// ===== tb/dedup_fifo_queue_unit_tb.sv =====
`timescale 1ns / 1ps

module dedup_fifo_queue_unit_tb;
  import dfq_pkg::*;

  localparam int QDEPTH        = 128;
  localparam int MAX_WAIT      = 18;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int DIRECTED_N    = 22;
  localparam int SETTLE_CYCLES = QDEPTH + 20;

  // One result of the queue, as seen on the output stream
  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   removed;
    logic [OCC_W-1:0]    occ;
  } queue_result_t;

  // One directed command; exp is used only when check is set
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [DATA_W-1:0]   value;
    logic                check;
    queue_result_t       exp;
  } stim_row_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_kind_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata;   // [31:0] item_value
  logic [CMD_W-1:0]     s_axis_tuser;   // [0] cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;   // [31:0] removed_value, [39:32] occupancy
  logic [STATUS_W-1:0]  m_axis_tuser;   // [2:0] status

  // Shadow copy of the stored values, oldest first
  logic [DATA_W-1:0]    shadow_entries [$];
  queue_result_t        pending_results [$];
  int                   mismatch_count = 0;

  // Hooks between the sender, the receiver and the transfer watcher
  logic                 row_check = 1'b0;
  queue_result_t        row_exp = '0;
  bit                   quiet_phase = 1'b0;
  int                   rx_hold_req = 0;

  stim_row_t directed_rows [DIRECTED_N] = '{
    '{CMD_DEQ, 32'h0000_0000, 1'b1, '{STS_EMPTY,     32'h0000_0000, 8'd0}},
    '{CMD_ENQ, 32'h8000_0000, 1'b1, '{STS_ENQUEUED,  32'h0000_0000, 8'd1}},
    '{CMD_ENQ, 32'h7FFF_FFFF, 1'b1, '{STS_ENQUEUED,  32'h0000_0000, 8'd2}},
    '{CMD_ENQ, 32'h8000_0000, 1'b1, '{STS_DUPLICATE, 32'h0000_0000, 8'd2}},
    '{CMD_ENQ, 32'h0000_0000, 1'b1, '{STS_ENQUEUED,  32'h0000_0000, 8'd3}},
    '{CMD_ENQ, 32'hFFFF_FFFF, 1'b1, '{STS_ENQUEUED,  32'h0000_0000, 8'd4}},
    '{CMD_ENQ, 32'h7FFF_FFFF, 1'b1, '{STS_DUPLICATE, 32'h0000_0000, 8'd4}},
    '{CMD_ENQ, 32'h0000_0000, 1'b1, '{STS_DUPLICATE, 32'h0000_0000, 8'd4}},
    '{CMD_DEQ, 32'hFFFF_FFFF, 1'b1, '{STS_DEQUEUED,  32'h8000_0000, 8'd3}},
    '{CMD_ENQ, 32'h8000_0000, 1'b1, '{STS_ENQUEUED,  32'h0000_0000, 8'd4}},
    '{CMD_ENQ, 32'hAAAA_AAAA, 1'b0, '0},
    '{CMD_ENQ, 32'h5555_5555, 1'b0, '0},
    '{CMD_ENQ, 32'h0000_0001, 1'b0, '0},
    '{CMD_DEQ, 32'hDEAD_BEEF, 1'b0, '0},
    '{CMD_ENQ, 32'h5555_5555, 1'b0, '0},
    '{CMD_DEQ, 32'h0000_0000, 1'b0, '0},
    '{CMD_DEQ, 32'h5555_5555, 1'b0, '0},
    '{CMD_DEQ, 32'hFFFF_FFFF, 1'b0, '0},
    '{CMD_DEQ, 32'h0000_0000, 1'b0, '0},
    '{CMD_DEQ, 32'hAAAA_AAAA, 1'b0, '0},
    '{CMD_DEQ, 32'h0000_0000, 1'b0, '0},
    '{CMD_DEQ, 32'h7FFF_FFFF, 1'b1, '{STS_EMPTY,     32'h0000_0000, 8'd0}}
  };

  dedup_fifo_queue_unit #(
    .DEPTH(QDEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one command to the shadow queue and return the result it must give
  function automatic queue_result_t dedup_queue_step(input logic [CMD_W-1:0] cmd,
                                                     input logic [DATA_W-1:0] val);
    queue_result_t r;
    bit            found;
    r     = '0;
    found = 1'b0;
    if (cmd == CMD_ENQ) begin
      foreach (shadow_entries[i]) begin
        if (shadow_entries[i] == val) found = 1'b1;
      end
      // duplicate wins over full
      if (found) begin
        r.status = STS_DUPLICATE;
      end else if (shadow_entries.size() >= QDEPTH) begin
        r.status = STS_FULL;
      end else begin
        shadow_entries.push_back(val);
        r.status = STS_ENQUEUED;
      end
    end else if (shadow_entries.size() == 0) begin
      r.status = STS_EMPTY;
    end else begin
      r.removed = shadow_entries.pop_front();
      r.status  = STS_DEQUEUED;
    end
    r.occ = OCC_W'(shadow_entries.size());
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Bias values toward stored ones and extremes so duplicates stay common
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 25 && shadow_entries.size() > 0)
      return shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
    if (sel < 35) begin
      case ($urandom_range(0, 4))
        0:       return 32'h0000_0000;
        1:       return 32'h8000_0000;
        2:       return 32'h7FFF_FFFF;
        3:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  // Offer one command after a random gap (none in a quiet phase); return at the negedge after its transfer
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val,
                          input logic check, input queue_result_t exp);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      s_axis_tuser  <= CMD_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    row_check = check;
    row_exp   = exp;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and hold until every outstanding result has arrived
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // Sender: reset, directed table, then random phases
  initial begin
    phase_kind_t kind;
    int          sent;
    int          phase_idx;
    int          phase_len;
    int          enq_pct;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].cmd, directed_rows[i].value,
               directed_rows[i].check, directed_rows[i].exp);
    end
    wait_drained();

    sent      = 0;
    phase_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      // first phase fills the queue past full
      if (phase_idx == 0) begin
        kind      = PH_FILL;
        phase_len = 260;
      end else begin
        kind      = phase_kind_t'($urandom_range(0, 2));
        phase_len = $urandom_range(80, 200);
      end
      case (kind)
        PH_FILL:  enq_pct = 85;
        PH_DRAIN: enq_pct = 15;
        default:  enq_pct = 50;
      endcase
      quiet_phase = (phase_idx % 4 == 3);
      if (phase_idx == 1) rx_hold_req = HOLD_CYCLES;
      for (int n = 0; n < phase_len; n++) begin
        if ($urandom_range(0, 99) < enq_pct)
          send_cmd(CMD_ENQ, pick_value(), 1'b0, '0);
        else
          send_cmd(CMD_DEQ, $urandom, 1'b0, '0);
        sent++;
      end
      if (phase_idx == 0 || $urandom_range(0, 1) == 1) wait_drained();
      phase_idx++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("** dedup_fifo_queue_unit: PASSED **");
    end else begin
      $display("** dedup_fifo_queue_unit: FAILED **");
    end
    $finish;
  end

  // Receiver: random stall per result, plus one long hold-off on request
  initial begin
    int wait_n;
    m_axis_tready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        wait_n      = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        wait_n = quiet_phase ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (wait_n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    queue_result_t predicted;
    queue_result_t oldest;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = dedup_queue_step(s_axis_tuser, s_axis_tdata);
        pending_results.push_back(row_check ? row_exp : predicted);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("result with nothing expected, status %0d", m_axis_tuser));
        end else begin
          oldest = pending_results.pop_front();
          if (m_axis_tuser !== oldest.status)
            note_mismatch($sformatf("status got %0d exp %0d", m_axis_tuser, oldest.status));
          if (m_axis_tdata[DATA_W-1:0] !== oldest.removed)
            note_mismatch($sformatf("removed_value got %h exp %h",
                                    m_axis_tdata[DATA_W-1:0], oldest.removed));
          if (m_axis_tdata[OUT_W-1:DATA_W] !== oldest.occ)
            note_mismatch($sformatf("occupancy got %0d exp %0d",
                                    m_axis_tdata[OUT_W-1:DATA_W], oldest.occ));
        end
      end
    end
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("** dedup_fifo_queue_unit: FAILED **");
    $finish;
  end

endmodule
